@@ sv/bpc_pkg.sv @@
// Shared types and constants for the button press classifier.
// No dependencies.
package bpc_pkg;

  localparam int unsigned NumButtonsDefault = 3;
  localparam int unsigned CountW = 16;
  localparam int unsigned LimitW = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned IdW = 2;

  localparam logic [LimitW-1:0] LongPressLimitRst = LimitW'(64);
  localparam logic [CountW-1:0] FailsafeLimitRst = CountW'(128 * 20);

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegLongPressLimit = 1'd0;
  localparam logic [CfgIdxW-1:0] RegFailsafeLimit = 1'd1;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_EDGE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DOWN       = 2'd0,
    KIND_SHORT_UP   = 2'd1,
    KIND_LONG_PRESS = 2'd2,
    KIND_LONG_UP    = 2'd3
  } kind_e;

  typedef struct packed {
    cmd_e           cmd;
    logic [IdW-1:0] button_id;
    logic           btn_level;
  } item_t;

  typedef struct packed {
    logic           valid;
    logic [IdW-1:0] button;
    kind_e          kind;
  } result_t;

endpackage

@@ sv/button_press_classifier.sv @@
// Top level of the button press classifier: input register, core, result register.
// Depends on bpc_pkg and bpc_core.
//
//  channel   direction  payload
//  s_axis    in         tdata: button_id, btn_level; tuser: cmd
//  m_axis    out        tdata: event_button; tuser: event_kind
//  cfg       in         cfg_idx_i selects register, cfg_data_i value
//
// one item per cycle sustained while the result register is free; each item is held in the
// input register, and an item with a result leaves through the result register.
// the per-item update of counter and stamps is combinational compare/add logic.
// reset clears counter, stamps, tick enable and both limits to their defaults.
// a stalled result holds the core; the input register still takes one more item.
module button_press_classifier import bpc_pkg::*; #(
  parameter int unsigned NumButtons = NumButtonsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [1:0] button_id, [2] btn_level
  input  logic                s_axis_tuser,   // [0] cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [1:0] event_button
  output logic [1:0]          m_axis_tuser,   // [1:0] event_kind
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic    in_vld_q;
  item_t   in_q;
  logic    out_vld_q;
  result_t out_q;
  logic    out_free;
  logic    fire;
  result_t res;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= '{cmd: cmd_e'(s_axis_tuser), button_id: s_axis_tdata[1:0],
                btn_level: s_axis_tdata[2]};
    end
  end

  bpc_core #(
    .NumButtons(NumButtons)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (in_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= fire && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid && out_free) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_q.button};
  assign m_axis_tuser  = out_q.kind;

  a_rise_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(fire))
    else $error("result appeared without a processed item");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res.valid |=> out_vld_q)
    else $error("result of a processed item was dropped");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> in_vld_q)
    else $error("accepted transaction not held in the input register");

endmodule

@@ sv/bpc_core.sv @@
// Classifier state: tick counter, press stamps, tick enable and config registers.
// Depends on bpc_pkg.
module bpc_core import bpc_pkg::*; #(
  parameter int unsigned NumButtons = NumButtonsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                fire_i,
  input  item_t               item_i,
  output result_t             res_o
);

  logic [LimitW-1:0] long_limit_q;
  logic [CountW-1:0] failsafe_q;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              en_q, en_d;
  logic [CountW-1:0] stamp_q [NumButtons];
  logic [CountW-1:0] stamp_d [NumButtons];

  logic              id_ok;
  logic [CountW-1:0] cnt_inc;
  logic [CountW-1:0] press_base;
  logic [CountW-1:0] sel_stamp;
  logic [CountW-1:0] held;
  logic [CountW-1:0] long_target;
  logic              hit;
  logic [IdW-1:0]    hit_id;
  logic              others_held;
  result_t           res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_limit_q <= LongPressLimitRst;
      failsafe_q   <= FailsafeLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLongPressLimit: long_limit_q <= cfg_data_i[LimitW-1:0];
        RegFailsafeLimit:  failsafe_q   <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign id_ok       = 32'(item_i.button_id) < NumButtons;
  assign cnt_inc     = cnt_q + CountW'(1);
  assign press_base  = en_q ? cnt_q : '0;
  assign long_target = CountW'(long_limit_q) + CountW'(1);
  assign held        = cnt_q - sel_stamp;

  always_comb begin
    sel_stamp   = '0;
    hit         = 1'b0;
    hit_id      = '0;
    others_held = 1'b0;
    for (int unsigned i = 0; i < NumButtons; i++) begin
      if (32'(item_i.button_id) == i) begin
        sel_stamp = stamp_q[i];
      end else if (stamp_q[i] != '0) begin
        others_held = 1'b1;
      end
      // later buttons win: a higher index overrides a lower one
      if (stamp_q[i] != '0 && (cnt_inc - stamp_q[i]) == long_target) begin
        hit    = 1'b1;
        hit_id = IdW'(i);
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    en_d  = en_q;
    for (int unsigned i = 0; i < NumButtons; i++) begin
      stamp_d[i] = stamp_q[i];
    end
    res = '{valid: 1'b0, button: item_i.button_id, kind: KIND_DOWN};
    if (item_i.cmd == CMD_TICK) begin
      if (en_q) begin
        cnt_d = cnt_inc;
        if (cnt_inc >= failsafe_q) begin
          en_d = 1'b0;
        end
        res = '{valid: hit, button: hit_id, kind: KIND_LONG_PRESS};
      end
    end else if (id_ok) begin
      if (item_i.btn_level) begin
        cnt_d = press_base;
        en_d  = 1'b1;
        for (int unsigned i = 0; i < NumButtons; i++) begin
          if (32'(item_i.button_id) == i) begin
            stamp_d[i] = press_base + CountW'(1);
          end
        end
        res = '{valid: 1'b1, button: item_i.button_id, kind: KIND_DOWN};
      end else begin
        for (int unsigned i = 0; i < NumButtons; i++) begin
          if (32'(item_i.button_id) == i) begin
            stamp_d[i] = '0;
          end
        end
        if (!others_held) begin
          en_d = 1'b0;
        end
        res.valid = 1'b1;
        res.kind  = (held > CountW'(long_limit_q)) ? KIND_LONG_UP : KIND_SHORT_UP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      en_q  <= 1'b0;
      for (int unsigned i = 0; i < NumButtons; i++) begin
        stamp_q[i] <= '0;
      end
    end else if (fire_i) begin
      cnt_q <= cnt_d;
      en_q  <= en_d;
      for (int unsigned i = 0; i < NumButtons; i++) begin
        stamp_q[i] <= stamp_d[i];
      end
    end
  end

  assign res_o = res;

  a_press_enables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.cmd == CMD_EDGE && item_i.btn_level && id_ok |=> en_q)
    else $error("tick source not running after a press");

  a_idle_tick_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.cmd == CMD_TICK && !en_q |=> $stable(cnt_q))
    else $error("counter moved on a tick while stopped");

  a_long_press_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.valid && res.kind == KIND_LONG_PRESS |-> item_i.cmd == CMD_TICK)
    else $error("long press reported on a button edge");

endmodule
